// ----- rtl/core/ldf_pkg.sv -----
`timescale 1ns / 1ps

package ldf_pkg;

  // Panel geometry.
  localparam int WIDTH       = 16;
  localparam int HEIGHT      = 16;
  localparam int NUM_PIX     = WIDTH * HEIGHT;
  localparam int FRAME_BYTES = NUM_PIX * 3;

  // Widths derived from the geometry.
  localparam int PIX_W  = $clog2(NUM_PIX);
  localparam int ADDR_W = PIX_W + 1;
  localparam int DEPTH  = 2 * NUM_PIX;
  localparam int X_W    = $clog2(WIDTH);
  localparam int Y_W    = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
  localparam int PX_W   = 24;

  // Width at which an LED index is compared against the pixel count.
  localparam int IDX_CMP_W = (PIX_W + 1 > 8) ? PIX_W + 1 : 8;

  // Protocol constants.
  localparam logic [7:0]  SYNC_A      = 8'hAA;
  localparam logic [7:0]  SYNC_B      = 8'h55;
  localparam logic [7:0]  CRC_POLY    = 8'h07;
  localparam logic [15:0] PAYLOAD_LEN = 16'(FRAME_BYTES);

  // Request command codes.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result kinds.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  // Frame status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LEN_ERR = 2'd1;
  localparam logic [1:0] ST_CRC_ERR = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
    logic [7:0] led_index;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] frame_status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_t;

  // Write into the pixel store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PX_W-1:0]   data;
  } pix_wr_t;

  // A result request handed to the response stage.
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [1:0] status;
    logic       blank;
  } rsp_req_t;

  // CRC-8, MSB first, one byte per call.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] din);
    logic [7:0] c;
    c = crc ^ din;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Flat store address of a pixel within a bank.
  function automatic logic [ADDR_W-1:0] bank_addr(input logic bank,
                                                   input logic [PIX_W-1:0] pix);
    logic [ADDR_W-1:0] base;
    base = bank ? ADDR_W'(NUM_PIX) : '0;
    return base + ADDR_W'(pix);
  endfunction

endpackage

// ----- rtl/core/ldf_ram.sv -----
`timescale 1ns / 1ps

module ldf_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/ldf_parser.sv -----
`timescale 1ns / 1ps

module ldf_parser
  import ldf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output pix_wr_t    wr,
  output rsp_req_t   evt,
  output logic       shown_bank,
  output logic       shown_live
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_SYNC2, PH_ID, PH_LEN_LO, PH_LEN_HI, PH_DATA, PH_CRC
  } phase_t;

  typedef enum logic [1:0] {LANE_R, LANE_G, LANE_B} lane_t;

  phase_t            phase_r, phase_nxt;
  lane_t             lane_r, lane_nxt;
  logic [7:0]        len_lo_r, len_lo_nxt;
  logic [7:0]        crc_r, crc_nxt;
  logic [15:0]       partial_r, partial_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic [Y_W-1:0]    y_r, y_nxt;
  logic [PIX_W-1:0]  row_base_r, row_base_nxt;
  logic              shown_r, shown_nxt;
  logic              live_r, live_nxt;
  logic [X_W-1:0]    col;
  logic [PIX_W-1:0]  serp;
  logic              last_pix;

  // Odd rows run right to left.
  assign col      = y_r[0] ? (X_W'(WIDTH - 1) - x_r) : x_r;
  assign serp     = row_base_r + PIX_W'(col);
  assign last_pix = (x_r == X_W'(WIDTH - 1)) && (y_r == Y_W'(HEIGHT - 1));

  always_comb begin
    phase_nxt    = phase_r;
    lane_nxt     = lane_r;
    len_lo_nxt   = len_lo_r;
    crc_nxt      = crc_r;
    partial_nxt  = partial_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    row_base_nxt = row_base_r;
    shown_nxt    = shown_r;
    live_nxt     = live_r;
    wr.en        = 1'b0;
    wr.addr      = bank_addr(~shown_r, serp);
    wr.data      = {partial_r, rx_byte};
    evt.valid    = 1'b0;
    evt.kind     = KIND_STATUS;
    evt.status   = ST_OK;
    evt.blank    = 1'b1;
    if (step) begin
      case (phase_r)
        PH_HUNT: begin
          if (rx_byte == SYNC_A) begin
            phase_nxt = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          phase_nxt = (rx_byte == SYNC_B) ? PH_ID : PH_HUNT;
        end
        PH_ID: begin
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_lo_nxt = rx_byte;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if ({rx_byte, len_lo_r} != PAYLOAD_LEN) begin
            evt.valid  = 1'b1;
            evt.status = ST_LEN_ERR;
            phase_nxt  = PH_HUNT;
          end else begin
            crc_nxt      = '0;
            partial_nxt  = '0;
            lane_nxt     = LANE_R;
            x_nxt        = '0;
            y_nxt        = '0;
            row_base_nxt = '0;
            phase_nxt    = PH_DATA;
          end
        end
        PH_DATA: begin
          crc_nxt = crc8_step(crc_r, rx_byte);
          case (lane_r)
            LANE_R: begin
              partial_nxt = {rx_byte, 8'h00};
              lane_nxt    = LANE_G;
            end
            LANE_G: begin
              partial_nxt = {partial_r[15:8], rx_byte};
              lane_nxt    = LANE_B;
            end
            LANE_B: begin
              wr.en    = 1'b1;
              lane_nxt = LANE_R;
              if (x_r == X_W'(WIDTH - 1)) begin
                x_nxt        = '0;
                y_nxt        = y_r + 1'b1;
                row_base_nxt = row_base_r + PIX_W'(WIDTH);
              end else begin
                x_nxt = x_r + 1'b1;
              end
              if (last_pix) begin
                phase_nxt = PH_CRC;
              end
            end
            default: begin
              lane_nxt = LANE_R;
            end
          endcase
        end
        PH_CRC: begin
          evt.valid = 1'b1;
          phase_nxt = PH_HUNT;
          if (rx_byte == crc_r) begin
            shown_nxt  = ~shown_r;
            live_nxt   = 1'b1;
            evt.status = ST_OK;
          end else begin
            evt.status = ST_CRC_ERR;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      lane_r     <= LANE_R;
      len_lo_r   <= '0;
      crc_r      <= '0;
      partial_r  <= '0;
      x_r        <= '0;
      y_r        <= '0;
      row_base_r <= '0;
      shown_r    <= 1'b0;
      live_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      lane_r     <= lane_nxt;
      len_lo_r   <= len_lo_nxt;
      crc_r      <= crc_nxt;
      partial_r  <= partial_nxt;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      row_base_r <= row_base_nxt;
      shown_r    <= shown_nxt;
      live_r     <= live_nxt;
    end
  end

  assign shown_bank = shown_r;
  assign shown_live = live_r;

endmodule

// ----- rtl/core/ldf_resp.sv -----
`timescale 1ns / 1ps

module ldf_resp
  import ldf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  rsp_req_t        req,
  input  logic [PX_W-1:0] rdata,
  output logic            can_accept,
  output logic            out_valid,
  input  logic            out_ready,
  output out_t            out_data
);

  logic     s1_vld_r, s1_vld_nxt;
  rsp_req_t s1_r;
  logic     out_vld_r, out_vld_nxt;
  out_t     out_r;
  logic     s1_go;
  out_t     formed;

  // The stage-one slot moves on whenever the output register is free or drained.
  assign s1_go      = !out_vld_r || out_ready;
  assign can_accept = !s1_vld_r || s1_go;

  always_comb begin
    formed              = '0;
    formed.kind         = s1_r.kind;
    formed.frame_status = s1_r.status;
    if ((s1_r.kind == KIND_PIXEL) && !s1_r.blank) begin
      formed.red   = rdata[23:16];
      formed.green = rdata[15:8];
      formed.blue  = rdata[7:0];
    end
  end

  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    out_vld_nxt = out_vld_r;
    if (s1_vld_r && s1_go) begin
      out_vld_nxt = 1'b1;
      s1_vld_nxt  = 1'b0;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (req.valid) begin
      s1_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    if (req.valid) begin
      s1_r <= req;
    end
    if (s1_vld_r && s1_go) begin
      out_r <= formed;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/led_frame_deframer_crc8_top.sv -----
`timescale 1ns / 1ps

// Serial LED frame deframer. Each request is either one received serial byte or a
// read of one displayed LED. Bytes are parsed for the sync pair 0xAA 0x55, a frame
// id, a little-endian length that must equal WIDTH*HEIGHT*3, the RGB payload and a
// CRC-8 (polynomial 0x07, initial value 0). Pixels land in the hidden bank of a
// double-buffered store at their serpentine position; a good CRC swaps the banks.
// Every frame that reaches the length or CRC check returns one status result, and
// every read returns one pixel result; other bytes return nothing. The block takes
// one request per clock. A result passes through two register stages on its way to
// the output: the first waits out the registered read of the pixel memory, the
// second is the output register. Intake stalls only while both of these stages are
// full and the consumer holds off out_ready. No clearing pass runs after reset:
// until the first good frame is shown, every read answers black.
module led_frame_deframer_crc8_top
  import ldf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic            in_acc;
  logic            byte_step;
  logic            read_step;
  logic            idx_ok;
  pix_wr_t         wr;
  rsp_req_t        evt;
  rsp_req_t        req;
  logic            shown_bank;
  logic            shown_live;
  logic [PX_W-1:0] rdata;
  logic            can_accept;

  assign in_ready  = can_accept;
  assign in_acc    = in_valid && in_ready;
  assign byte_step = in_acc && (in_data.cmd == CMD_BYTE);
  assign read_step = in_acc && (in_data.cmd == CMD_READ);
  assign idx_ok    = IDX_CMP_W'(in_data.led_index) < IDX_CMP_W'(NUM_PIX);

  // The parser owns the frame state, the staging writes and the bank select.
  ldf_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (byte_step),
    .rx_byte    (in_data.rx_byte),
    .wr         (wr),
    .evt        (evt),
    .shown_bank (shown_bank),
    .shown_live (shown_live)
  );

  // Reads always target the shown bank and writes the hidden one, so the two
  // ports never touch the same entry.
  ldf_ram #(
    .DATA_W (PX_W),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (read_step),
    .raddr (bank_addr(shown_bank, PIX_W'(in_data.led_index))),
    .rdata (rdata)
  );

  // Merge the two possible result sources; only one request is taken per cycle.
  always_comb begin
    req = evt;
    if (read_step) begin
      req.valid  = 1'b1;
      req.kind   = KIND_PIXEL;
      req.status = ST_OK;
      req.blank  = !idx_ok || !shown_live;
    end
  end

  ldf_resp u_resp (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .rdata      (rdata),
    .can_accept (can_accept),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- dv/tb_led_frame_deframer_crc8_top.sv -----
`timescale 1ns / 1ps

module tb_led_frame_deframer_crc8_top;
  import ldf_pkg::*;

  // Clock, reset and the two request/result channels. Every input starts at a known value.
  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  always #1 clk = ~clk;

  led_frame_deframer_crc8_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Parser phases of the shadow deframer.
  typedef enum logic [2:0] {
    HUNT_A, WAIT_B, SKIP_ID, LEN_LO, LEN_HI, PAYLOAD, CRC_BYTE
  } parse_phase_e;

  // Requests waiting to be driven, and results that the block still owes us.
  in_t  requests_to_send[$];
  out_t results_owed[$];

  // Shadow state of the deframer, updated as each request is accepted.
  parse_phase_e phase    = HUNT_A;
  logic [7:0]   len_lo   = '0;
  int           taken    = 0;
  logic [7:0]   crc_acc  = '0;
  logic [15:0]  rg_hold  = '0;
  bit           shown_bank = 1'b0;
  logic [23:0]  frame_store [2*NUM_PIX];

  // Bookkeeping for the end of the run and the summary.
  int n_accepted = 0;
  int n_reads    = 0;
  int n_shown    = 0;
  int n_len_err  = 0;
  int n_crc_err  = 0;
  int n_checked  = 0;
  int mismatches = 0;

  // Per-side idle control. A "calm" side runs back to back until it flips again.
  int in_gap   = 0;
  int out_hold = 0;
  bit in_calm  = 1'b0;
  bit out_calm = 1'b0;

  // CRC-8, polynomial 0x07, MSB first, one byte at a time.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] din);
    logic [7:0] r;
    r = crc ^ din;
    repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  // Physical LED slot of a pixel in stream order: odd rows run right to left.
  function automatic int serp_slot(input int pix);
    int row;
    int col;
    row = pix / WIDTH;
    col = pix % WIDTH;
    if (row % 2 == 1) col = WIDTH - 1 - col;
    return row * WIDTH + col;
  endfunction

  // Advance the shadow deframer by one accepted request and queue whatever result it owes.
  task automatic track_deframer(input in_t req);
    out_t        r;
    logic [23:0] px;
    int          lane;
    r = '0;
    n_accepted++;
    if (req.cmd == CMD_READ) begin
      // A read never touches the parser and always sees the shown bank.
      n_reads++;
      px = '0;
      if (int'(req.led_index) < NUM_PIX)
        px = frame_store[(shown_bank ? NUM_PIX : 0) + int'(req.led_index)];
      r.kind = KIND_PIXEL;
      r.frame_status = ST_OK;
      {r.red, r.green, r.blue} = px;
      results_owed.push_back(r);
    end else begin
      case (phase)
        HUNT_A: begin
          if (req.rx_byte == SYNC_A) phase = WAIT_B;
        end
        WAIT_B: begin
          // A wrong second sync byte is dropped outright, even when it is itself 0xAA.
          phase = (req.rx_byte == SYNC_B) ? SKIP_ID : HUNT_A;
        end
        SKIP_ID: phase = LEN_LO;
        LEN_LO: begin
          len_lo = req.rx_byte;
          phase  = LEN_HI;
        end
        LEN_HI: begin
          if ({req.rx_byte, len_lo} != PAYLOAD_LEN) begin
            phase = HUNT_A;
            n_len_err++;
            r.kind = KIND_STATUS;
            r.frame_status = ST_LEN_ERR;
            results_owed.push_back(r);
          end else begin
            taken   = 0;
            crc_acc = '0;
            rg_hold = '0;
            phase   = PAYLOAD;
          end
        end
        PAYLOAD: begin
          lane    = taken % 3;
          crc_acc = crc8_next(crc_acc, req.rx_byte);
          if (lane == 0) begin
            rg_hold = {req.rx_byte, 8'h00};
          end else if (lane == 1) begin
            rg_hold[7:0] = req.rx_byte;
          end else begin
            // The blue byte completes a pixel, which lands in the hidden bank.
            frame_store[(shown_bank ? 0 : NUM_PIX) + serp_slot(taken / 3)] =
              {rg_hold, req.rx_byte};
          end
          taken++;
          if (taken >= FRAME_BYTES) phase = CRC_BYTE;
        end
        CRC_BYTE: begin
          phase = HUNT_A;
          r.kind = KIND_STATUS;
          if (req.rx_byte == crc_acc) begin
            shown_bank = !shown_bank;
            r.frame_status = ST_OK;
            n_shown++;
          end else begin
            r.frame_status = ST_CRC_ERR;
            n_crc_err++;
          end
          results_owed.push_back(r);
        end
        default: phase = HUNT_A;
      endcase
    end
  endtask

  // Request builders. led_index and rx_byte are random where the command ignores them.
  task automatic push_byte(input logic [7:0] b);
    in_t r;
    r.cmd       = CMD_BYTE;
    r.rx_byte   = b;
    r.led_index = 8'($urandom_range(0, 255));
    requests_to_send.push_back(r);
  endtask

  task automatic push_read(input logic [7:0] idx);
    in_t r;
    r.cmd       = CMD_READ;
    r.rx_byte   = 8'($urandom_range(0, 255));
    r.led_index = idx;
    requests_to_send.push_back(r);
  endtask

  // A byte of a multi-byte sequence, now and then preceded by a read of a random LED.
  task automatic push_seq_byte(input logic [7:0] b);
    if ($urandom_range(0, 31) == 0) push_read(8'($urandom_range(0, 255)));
    push_byte(b);
  endtask

  task automatic push_header(input logic [15:0] len);
    push_seq_byte(SYNC_A);
    push_seq_byte(SYNC_B);
    push_seq_byte(8'($urandom_range(0, 255)));
    push_seq_byte(len[7:0]);
    push_seq_byte(len[15:8]);
  endtask

  // A full frame of random pixels with its CRC, optionally damaged.
  task automatic push_frame(input bit corrupt);
    logic [7:0] crc;
    logic [7:0] b;
    crc = '0;
    push_header(PAYLOAD_LEN);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      b   = 8'($urandom_range(0, 255));
      crc = crc8_next(crc, b);
      push_seq_byte(b);
    end
    push_seq_byte(corrupt ? (crc ^ 8'($urandom_range(1, 255))) : crc);
  endtask

  // Short sequences between frames. Each one leaves the parser hunting again, so the
  // next frame header is always recognized.
  task automatic push_filler(input int count);
    int          stop_at;
    logic [7:0]  b;
    logic [15:0] len;
    stop_at = requests_to_send.size() + count;
    while (requests_to_send.size() < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_read(8'($urandom_range(0, 255)));
        4, 5: begin
          // Line noise that never contains a first sync byte.
          b = 8'($urandom_range(0, 254));
          if (b >= SYNC_A) b++;
          push_byte(b);
        end
        6: begin
          // Broken sync pair; when the dropped byte is 0xAA a stray 0x55 may follow.
          b = 8'($urandom_range(0, 254));
          if (b >= SYNC_B) b++;
          push_seq_byte(SYNC_A);
          push_seq_byte(b);
          if (b == SYNC_A && $urandom_range(0, 1) == 1) push_seq_byte(SYNC_B);
        end
        7, 8: begin
          // Header with a bad length: anything, or just one of its two bytes wrong.
          case ($urandom_range(0, 2))
            0:       len = PAYLOAD_LEN ^ 16'($urandom_range(1, 65535));
            1:       len = {PAYLOAD_LEN[15:8] ^ 8'($urandom_range(1, 255)),
                            PAYLOAD_LEN[7:0]};
            default: len = {PAYLOAD_LEN[15:8],
                            PAYLOAD_LEN[7:0] ^ 8'($urandom_range(1, 255))};
          endcase
          push_header(len);
        end
        default: begin
          repeat ($urandom_range(4, 8)) push_read(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  // Driver: presents queued requests, idling a random number of cycles after each one.
  // The shadow model advances on the request that is accepted at this edge.
  always @(posedge clk) begin : request_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) track_deframer(in_data);
      // The slot is free when nothing is shown or the shown request is taken now.
      if (!in_valid || in_ready) begin
        if (in_gap != 0 || requests_to_send.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap != 0) in_gap--;
        end else begin
          in_valid <= 1'b1;
          in_data  <= requests_to_send.pop_front();
          if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
          in_gap = in_calm ? 0 : $urandom_range(0, 11);
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest one owed, then holds off
  // out_ready for a random number of cycles before taking the next.
  always @(posedge clk) begin : result_monitor
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (results_owed.size() == 0) begin
          $error("result with nothing owed: %p", out_data);
          mismatches++;
        end else begin
          want = results_owed.pop_front();
          if (out_data.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
            mismatches++;
          end
          if (out_data.frame_status !== want.frame_status) begin
            $error("frame_status: expected %0d, got %0d", want.frame_status,
                   out_data.frame_status);
            mismatches++;
          end
          if (out_data.red !== want.red) begin
            $error("red: expected %0h, got %0h", want.red, out_data.red);
            mismatches++;
          end
          if (out_data.green !== want.green) begin
            $error("green: expected %0h, got %0h", want.green, out_data.green);
            mismatches++;
          end
          if (out_data.blue !== want.blue) begin
            $error("blue: expected %0h, got %0h", want.blue, out_data.blue);
            mismatches++;
          end
        end
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_hold = out_calm ? 0 : $urandom_range(0, 11);
      end
      if (out_hold != 0) begin
        out_ready <= 1'b0;
        out_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Builds the whole request stream, releases reset, then waits for the block to drain.
  initial begin : run_control
    int total;
    foreach (frame_store[i]) frame_store[i] = '0;

    // Directed part. Both ends of the LED range read black straight after reset.
    push_read(8'h00);
    push_read(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    // Sync pair broken by a plain byte.
    push_byte(SYNC_A);
    push_byte(8'h00);
    // A second 0xAA is dropped, so the 0x55 after it is just noise.
    push_byte(SYNC_A);
    push_byte(SYNC_A);
    push_byte(SYNC_B);
    // Bad lengths: zero, all ones, and a right low byte with a wrong high byte.
    push_byte(SYNC_A);
    push_byte(SYNC_B);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(SYNC_A);
    push_byte(SYNC_B);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(SYNC_A);
    push_byte(SYNC_B);
    push_byte(8'h7F);
    push_byte(PAYLOAD_LEN[7:0]);
    push_byte(PAYLOAD_LEN[15:8] ^ 8'h01);

    // Random part: a good frame that gets shown, then a frame with a bad CRC whose
    // partial data must stay hidden, with reads sprinkled through both and after.
    push_filler(40);
    push_frame(1'b0);
    push_filler(30);
    push_frame(1'b1);
    push_filler(50);
    total = requests_to_send.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < total) @(posedge clk);
    while (results_owed.size() != 0) @(posedge clk);
    // A few more cycles so that any stray result still gets caught.
    repeat (12) @(posedge clk);

    $display("Covered %0d requests including %0d LED reads; %0d results checked.",
             n_accepted, n_reads, n_checked);
    $display("Frames: %0d shown, %0d rejected on length, %0d rejected on CRC.",
             n_shown, n_len_err, n_crc_err);
    if (mismatches == 0) begin
      $display("led_frame_deframer_crc8_top verification clean");
    end else begin
      $display("led_frame_deframer_crc8_top verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run of this stream.
  initial begin : watchdog
    #2_000_000;
    $display("led_frame_deframer_crc8_top verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ldf_pkg.sv
rtl/core/ldf_ram.sv
rtl/core/ldf_parser.sv
rtl/core/ldf_resp.sv
rtl/core/led_frame_deframer_crc8_top.sv
dv/tb_led_frame_deframer_crc8_top.sv
